/* rtl/mlqtp_pkg.sv */
// Package for the multilevel queue task picker: table size, item and entry
// types, reset entry and opcodes. No dependencies.
`default_nettype none

package mlqtp_pkg;

  localparam int TaskCount = 8;
  localparam int IdxW      = $clog2(TaskCount);
  localparam int CntW      = $clog2(TaskCount + 1);

  localparam logic [1:0] RrLevel = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SCHED = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  entry_index;
    logic [1:0]  queue_level;
    logic [7:0]  task_priority;
    logic        has_arrived;
    logic [15:0] ticks_left;
  } in_item_t;

  typedef struct packed {
    logic [2:0] selected_task;
    logic       all_finished;
  } out_item_t;

  typedef struct packed {
    logic [1:0] level;
    logic [7:0] prio;
    logic       arrived;
    logic       finished;
  } entry_t;

  localparam entry_t EntryReset = '{level: RrLevel, prio: 8'd0, arrived: 1'b0, finished: 1'b1};

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    entry_t          entry;
  } tbl_wr_t;

endpackage

`default_nettype wire

/* rtl/mlqtp_if.sv */
// Valid/ready channel interfaces for input items and result items.
// Depends on mlqtp_pkg for the payload types.
`default_nettype none

interface mlqtp_in_if;
  import mlqtp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface mlqtp_out_if;
  import mlqtp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/mlqtp_table.sv */
// Task table: one synchronous memory with one write and one registered read
// port, plus per-entry valid bits so unwritten entries read as the reset entry.
// Depends on mlqtp_pkg.
`default_nettype none

module mlqtp_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mlqtp_pkg::tbl_wr_t         wr_i,
  input  logic [mlqtp_pkg::IdxW-1:0] rd_addr_i,
  output mlqtp_pkg::entry_t          rd_entry_o
);
  import mlqtp_pkg::*;

  entry_t               mem_q [TaskCount];
  entry_t               rd_data_q;
  logic [TaskCount-1:0] valid_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.entry;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      rd_vld_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_vld_q ? rd_data_q : EntryReset;

endmodule

`default_nettype wire

/* rtl/mlqtp_ctrl.sv */
// Sequencer of the task picker: accepts items, writes the table, scans it one
// entry per cycle after the current task, and holds the result register.
// Depends on mlqtp_pkg and the channel interfaces.
`default_nettype none

module mlqtp_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  mlqtp_in_if.sink                   in_i,
  mlqtp_out_if.source                out_o,
  output mlqtp_pkg::tbl_wr_t         wr_o,
  output logic [mlqtp_pkg::IdxW-1:0] rd_addr_o,
  input  mlqtp_pkg::entry_t          rd_entry_i
);
  import mlqtp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PUT  = 2'd2;

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] i);
    next_idx = (i == IdxW'(TaskCount - 1)) ? '0 : i + 1'b1;
  endfunction

  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] cur_q, cur_d;
  logic [IdxW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] iss_cnt_q, iss_cnt_d;
  logic            proc_vld_q, proc_vld_d;
  logic            proc_last_q, proc_last_d;
  logic [IdxW-1:0] proc_addr_q, proc_addr_d;

  // Scan accumulators.
  logic            all_l3_q, all_l3_d;
  logic            all_arr_q, all_arr_d;
  logic            all_fin_q, all_fin_d;
  logic            rr_found_q, rr_found_d;
  logic [IdxW-1:0] rr_pick_q, rr_pick_d;
  logic [1:0]      best_lvl_q, best_lvl_d;
  logic [7:0]      best_prio_q, best_prio_d;
  logic [IdxW-1:0] pick_q, pick_d;

  out_item_t       res_q, res_d;
  logic            out_vld_q, out_vld_d;
  out_item_t       out_data_q, out_data_d;

  logic            in_beat;
  logic            issuing;
  logic            in_range;

  assign in_beat  = in_i.valid && in_i.ready;
  assign issuing  = (state_q == S_SCAN) && (iss_cnt_q != CntW'(TaskCount));
  assign in_range = 32'(in_i.data.entry_index) < 32'(TaskCount);

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_data_q;
  assign rd_addr_o   = rd_ptr_q;

  always_comb begin
    wr_o.en             = in_beat && (in_i.data.opcode == OP_WRITE) && in_range;
    wr_o.addr           = IdxW'(in_i.data.entry_index);
    wr_o.entry.level    = in_i.data.queue_level;
    wr_o.entry.prio     = in_i.data.task_priority;
    wr_o.entry.arrived  = in_i.data.has_arrived;
    wr_o.entry.finished = (in_i.data.ticks_left == 16'd0);
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    rd_ptr_d    = rd_ptr_q;
    iss_cnt_d   = iss_cnt_q;
    proc_vld_d  = issuing;
    proc_last_d = issuing && (iss_cnt_q == CntW'(TaskCount - 1));
    proc_addr_d = rd_ptr_q;
    all_l3_d    = all_l3_q;
    all_arr_d   = all_arr_q;
    all_fin_d   = all_fin_q;
    rr_found_d  = rr_found_q;
    rr_pick_d   = rr_pick_q;
    best_lvl_d  = best_lvl_q;
    best_prio_d = best_prio_q;
    pick_d      = pick_q;
    res_d       = res_q;
    out_vld_d   = out_vld_q && !out_o.ready;
    out_data_d  = out_data_q;

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          if (in_i.data.opcode == OP_WRITE) begin
            res_d.selected_task = 3'(cur_q);
            res_d.all_finished  = 1'b0;
            state_d             = S_PUT;
          end else begin
            rd_ptr_d    = next_idx(cur_q);
            iss_cnt_d   = '0;
            all_l3_d    = 1'b1;
            all_arr_d   = 1'b1;
            all_fin_d   = 1'b1;
            rr_found_d  = 1'b0;
            rr_pick_d   = cur_q;
            best_lvl_d  = RrLevel;
            best_prio_d = 8'd0;
            pick_d      = cur_q;
            state_d     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issuing) begin
          rd_ptr_d  = next_idx(rd_ptr_q);
          iss_cnt_d = iss_cnt_q + 1'b1;
        end
        if (proc_vld_q) begin
          all_l3_d  = all_l3_q && (rd_entry_i.level == RrLevel);
          all_arr_d = all_arr_q && rd_entry_i.arrived;
          all_fin_d = all_fin_q && rd_entry_i.arrived && rd_entry_i.finished;
          if (!rr_found_q && rd_entry_i.arrived && !rd_entry_i.finished) begin
            rr_found_d = 1'b1;
            rr_pick_d  = proc_addr_q;
          end
          // A lower level restarts the priority race; within the level a
          // later entry wins ties.
          if (rd_entry_i.arrived && (rd_entry_i.level < best_lvl_q)) begin
            best_lvl_d  = rd_entry_i.level;
            best_prio_d = rd_entry_i.prio;
            pick_d      = proc_addr_q;
          end else if (rd_entry_i.arrived && (rd_entry_i.level == best_lvl_q) &&
                       (rd_entry_i.prio >= best_prio_q)) begin
            best_prio_d = rd_entry_i.prio;
            pick_d      = proc_addr_q;
          end
          if (proc_last_q) begin
            if (all_l3_d && all_arr_d) begin
              cur_d              = rr_found_d ? rr_pick_d : cur_q;
              res_d.all_finished = all_fin_d;
            end else begin
              cur_d              = pick_d;
              res_d.all_finished = 1'b0;
            end
            res_d.selected_task = 3'(cur_d);
            state_d             = S_PUT;
          end
        end
      end
      S_PUT: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d  = 1'b1;
          out_data_d = res_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      iss_cnt_q   <= '0;
      proc_vld_q  <= 1'b0;
      proc_last_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      iss_cnt_q   <= iss_cnt_d;
      proc_vld_q  <= proc_vld_d;
      proc_last_q <= proc_last_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q    <= rd_ptr_d;
    proc_addr_q <= proc_addr_d;
    all_l3_q    <= all_l3_d;
    all_arr_q   <= all_arr_d;
    all_fin_q   <= all_fin_d;
    rr_found_q  <= rr_found_d;
    rr_pick_q   <= rr_pick_d;
    best_lvl_q  <= best_lvl_d;
    best_prio_q <= best_prio_d;
    pick_q      <= pick_d;
    res_q       <= res_d;
    out_data_q  <= out_data_d;
  end

  // Table data is only consumed while a scan is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_vld_q |-> (state_q == S_SCAN))
    else $error("table read data consumed outside a scan");

  // Once all reads are issued, the last entry is being processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) && !issuing) |-> (proc_vld_q && proc_last_q))
    else $error("scan finished issuing without a final entry in flight");

  // The current task pointer stays inside the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_q) < 32'(TaskCount))
    else $error("current task pointer out of range");

  // A pending result waits while the output register is still occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_PUT) && out_vld_q && !out_o.ready) |=>
      ((state_q == S_PUT) && out_vld_q))
    else $error("result register overwritten before its beat");

endmodule

`default_nettype wire

/* rtl/multilevel_queue_task_picker.sv */
// Multilevel queue task picker. A write item loads one table entry and returns
// the unchanged current task. A schedule item reads the task table through a
// single registered memory read port, one entry per cycle in circular order
// starting after the current task. One item is in work at a time; the result
// register lets the next item be accepted while the previous result still
// waits on the output. Unwritten entries read as level 3, priority 0, not
// arrived, finished.
// Depends on mlqtp_pkg, mlqtp_if, mlqtp_table and mlqtp_ctrl.
`default_nettype none

module multilevel_queue_task_picker (
  input  logic        clk_i,
  input  logic        rst_ni,
  mlqtp_in_if.sink    in_i,
  mlqtp_out_if.source out_o
);
  import mlqtp_pkg::*;

  tbl_wr_t         tbl_wr;
  logic [IdxW-1:0] tbl_rd_addr;
  entry_t          tbl_rd_entry;

  mlqtp_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (tbl_wr),
    .rd_addr_i  (tbl_rd_addr),
    .rd_entry_o (tbl_rd_entry)
  );

  mlqtp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .wr_o       (tbl_wr),
    .rd_addr_o  (tbl_rd_addr),
    .rd_entry_i (tbl_rd_entry)
  );

endmodule

`default_nettype wire
